@@ sv/ffbs_pkg.sv @@
// Shared types, constants and helpers of the first-fit block suballocator.
// Depends on nothing; the size unit, top level and checker use it through scoped names.
package ffbs_pkg;

    localparam int MAX_BLOCKS = 8;
    localparam int MAX_SLOTS  = 32;
    localparam int RANGES     = MAX_SLOTS + 1;
    localparam int BLK_W      = 3;
    localparam int BCNT_W     = $clog2(MAX_BLOCKS + 1);
    localparam int SLOT_W     = 5;
    localparam int IDX_W      = $clog2(RANGES + 1);
    localparam int RADDR_W    = $clog2(MAX_BLOCKS * RANGES);
    localparam int INFL_W     = 16;
    localparam int SZ_W       = 32;
    localparam int AL_W       = 17;
    localparam int RANGE_W    = 2 * SZ_W;
    localparam int SLOTD_W    = BLK_W + 2 * SZ_W;

    // request codes
    localparam logic [1:0] FN_ALLOC   = 2'd0;
    localparam logic [1:0] FN_FREE    = 2'd1;
    localparam logic [1:0] FN_ACQUIRE = 2'd2;
    localparam logic [1:0] FN_RELEASE = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO      = 3'd1;
    localparam logic [2:0] ST_NO_BLOCK  = 3'd2;
    localparam logic [2:0] ST_NO_SLOT   = 3'd3;
    localparam logic [2:0] ST_WILD      = 3'd4;
    localparam logic [2:0] ST_DEFERRED  = 3'd5;
    localparam logic [2:0] ST_REFUSED   = 3'd6;
    localparam logic [2:0] ST_UNDERFLOW = 3'd7;

    // configuration register indexes
    localparam logic [7:0] CFG_BLOCK_BYTES = 8'd0;
    localparam logic [7:0] CFG_ALIGN_BYTES = 8'd1;

    typedef struct packed {
        logic [1:0]        func;
        logic [SZ_W-1:0]   alloc_size;
        logic [SLOT_W-1:0] handle;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] new_handle;
        logic [BLK_W-1:0]  blk_no;
        logic [SZ_W-1:0]   offset;
        logic [SZ_W-1:0]   capacity;
        logic              freed;
    } t_out_item;

    // rounded sizes handed from the size unit to the sequencer
    typedef struct packed {
        logic [SZ_W-1:0] req;      // rounded request
        logic            req_ovf;  // rounded request does not fit
        logic [SZ_W-1:0] blk;      // rounded (saturated) block size
    } t_size_info;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOT,
        S_AL_START,
        S_AL_SCAN,
        S_AL_CMP,
        S_AL_NEW,
        S_FR_SCAN,
        S_FR_CMP,
        S_SHL_RD,
        S_SHL_WR,
        S_SHR_RD,
        S_SHR_WR,
        S_EMIT
    } t_state;

    function automatic logic [RADDR_W-1:0] f_raddr(input logic [BLK_W-1:0] b,
                                                   input logic [IDX_W-1:0] i);
        f_raddr = RADDR_W'(b) * RADDR_W'(RANGES) + RADDR_W'(i);
    endfunction

endpackage

@@ sv/ffbs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module ffbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 264
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/ffbs_size.sv @@
// Size unit: effective alignment, rounded request and rounded block size.
// Depends on ffbs_pkg.
module ffbs_size (
    input  logic [ffbs_pkg::AL_W-1:0] i_align,
    input  logic [ffbs_pkg::SZ_W-1:0] i_block_bytes,
    input  logic [ffbs_pkg::SZ_W-1:0] i_size,
    output ffbs_pkg::t_size_info      o_info
);
    logic [ffbs_pkg::AL_W-1:0] al;
    logic [ffbs_pkg::SZ_W:0]   am1;
    logic [ffbs_pkg::SZ_W:0]   base;
    logic [ffbs_pkg::SZ_W:0]   a33;
    logic [ffbs_pkg::SZ_W:0]   b33;

    // largest power of two not above the register, at least 4
    always_comb begin
        al = ffbs_pkg::AL_W'(4);
        for (int k = 3; k < ffbs_pkg::AL_W; k++) begin
            if (i_align[k]) begin
                al = ffbs_pkg::AL_W'(1) << k;
            end
        end
    end

    assign am1  = (ffbs_pkg::SZ_W+1)'(al) - (ffbs_pkg::SZ_W+1)'(1);
    assign base = (i_size < ffbs_pkg::SZ_W'(4)) ? (ffbs_pkg::SZ_W+1)'(4)
                                                : {1'b0, i_size};
    assign a33  = (base + am1) & ~am1;
    assign b33  = ({1'b0, i_block_bytes} + am1) & ~am1;

    assign o_info.req     = a33[ffbs_pkg::SZ_W-1:0];
    assign o_info.req_ovf = a33[ffbs_pkg::SZ_W];
    assign o_info.blk     = b33[ffbs_pkg::SZ_W] ? ~am1[ffbs_pkg::SZ_W-1:0]
                                                : b33[ffbs_pkg::SZ_W-1:0];
endmodule

@@ sv/first_fit_block_suballocator.sv @@
// Top level of the first-fit block suballocator: sequencer, slot flops, config.
// Depends on ffbs_pkg, ffbs_ram and ffbs_size.
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_in  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item at a time; a new item is taken once the result is in the output register.
// A wild handle goes straight to the result; acquire, release and free errors follow the
// slot read, early allocate errors the size checks. Allocate skips blocks, compares
// ranges and may open a new block; a used-up range shifts later entries down. Free
// compares ranges until one lies past the freed range or the list ends, then shifts
// entries for an insert or a double join. Reset is synchronous; range and slot memories
// need no clearing pass. A stalled result holds in the output register.
module first_fit_block_suballocator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ffbs_pkg::t_in_item    i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ffbs_pkg::t_out_item   o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [7:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    localparam int NB = ffbs_pkg::MAX_BLOCKS;
    localparam int NS = ffbs_pkg::MAX_SLOTS;
    localparam int IW = ffbs_pkg::IDX_W;
    localparam int SW = ffbs_pkg::SZ_W;
    localparam int BW = ffbs_pkg::BLK_W;

    ffbs_pkg::t_state    r_state, n_state;
    ffbs_pkg::t_in_item  r_item, n_item;
    ffbs_pkg::t_out_item r_res, n_res;
    ffbs_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic [SW-1:0]               r_block_bytes;
    logic [ffbs_pkg::AL_W-1:0]   r_align_bytes;

    logic [NB-1:0]    r_bvalid, n_bvalid;
    logic [IW-1:0]    r_cnt [NB];
    logic [IW-1:0]    n_cnt [NB];
    logic [NS-1:0]    r_svalid, n_svalid;
    logic [NS-1:0]    r_pend, n_pend;
    logic [ffbs_pkg::INFL_W-1:0] r_infl [NS];
    logic [ffbs_pkg::INFL_W-1:0] n_infl [NS];

    logic [ffbs_pkg::BCNT_W-1:0] r_b, n_b;
    logic [IW-1:0]     r_i, n_i, r_n, n_n, r_k, n_k;
    logic [ffbs_pkg::SLOT_W-1:0] r_h, n_h;
    logic [SW-1:0]     r_a, n_a, r_off, n_off, r_cap, n_cap;
    logic [SW-1:0]     r_ps, n_ps, r_pl, n_pl;

    // memory ports
    logic                           rwe, swe;
    logic [ffbs_pkg::RADDR_W-1:0]   rwaddr, rraddr;
    logic [ffbs_pkg::RANGE_W-1:0]   rwdata, rrdata;
    logic [ffbs_pkg::SLOT_W-1:0]    swaddr;
    logic [ffbs_pkg::SLOTD_W-1:0]   swdata, srdata;

    ffbs_pkg::t_size_info sz;
    logic [SW-1:0] rd_s, rd_l;
    logic [BW-1:0] cur_b;
    logic          jp, jn;
    logic          fs_found, nb_found;
    logic [ffbs_pkg::SLOT_W-1:0] fs_idx;
    logic [BW-1:0] nb_idx;
    logic [SW-1:0] bsize;
    logic [ffbs_pkg::INFL_W-1:0] infl_h;

    ffbs_ram #(.WIDTH(ffbs_pkg::RANGE_W), .DEPTH(NB * ffbs_pkg::RANGES)) u_range_ram (
        .i_clk(i_clk), .i_we(rwe), .i_waddr(rwaddr), .i_wdata(rwdata),
        .i_raddr(rraddr), .o_rdata(rrdata)
    );

    ffbs_ram #(.WIDTH(ffbs_pkg::SLOTD_W), .DEPTH(NS)) u_slot_ram (
        .i_clk(i_clk), .i_we(swe), .i_waddr(swaddr), .i_wdata(swdata),
        .i_raddr(i_in.handle), .o_rdata(srdata)
    );

    ffbs_size u_size (
        .i_align(r_align_bytes), .i_block_bytes(r_block_bytes),
        .i_size(r_item.alloc_size), .o_info(sz)
    );

    assign o_in_ready  = (r_state == ffbs_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign rd_s  = rrdata[ffbs_pkg::RANGE_W-1:SW];
    assign rd_l  = rrdata[SW-1:0];
    assign cur_b = r_b[BW-1:0];
    assign bsize = (sz.blk > r_a) ? sz.blk : r_a;
    assign infl_h = r_infl[r_item.handle];

    // first free slot and first unused block
    always_comb begin
        fs_found = 1'b0;
        fs_idx   = '0;
        for (int s = NS - 1; s >= 0; s--) begin
            if (!r_svalid[s]) begin
                fs_found = 1'b1;
                fs_idx   = ffbs_pkg::SLOT_W'(s);
            end
        end
        nb_found = 1'b0;
        nb_idx   = '0;
        for (int b = NB - 1; b >= 0; b--) begin
            if (!r_bvalid[b]) begin
                nb_found = 1'b1;
                nb_idx   = BW'(b);
            end
        end
    end

    // neighbor joins on a free
    assign jp = (r_i != '0) &&
                (({1'b0, r_ps} + {1'b0, r_pl}) == {1'b0, r_off});
    assign jn = (r_state == ffbs_pkg::S_FR_CMP) &&
                (({1'b0, r_off} + {1'b0, r_cap}) == {1'b0, rd_s});

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_res    = r_res;
        n_bvalid = r_bvalid;
        n_cnt    = r_cnt;
        n_svalid = r_svalid;
        n_pend   = r_pend;
        n_infl   = r_infl;
        n_b = r_b; n_i = r_i; n_n = r_n; n_k = r_k; n_h = r_h;
        n_a = r_a; n_off = r_off; n_cap = r_cap; n_ps = r_ps; n_pl = r_pl;
        rwe    = 1'b0;
        rwaddr = ffbs_pkg::f_raddr(cur_b, r_i);
        rwdata = {r_off, r_cap};
        rraddr = ffbs_pkg::f_raddr(cur_b, r_i);
        swe    = 1'b0;
        swaddr = r_h;
        swdata = {cur_b, rd_s, r_a};

        unique case (r_state)
            ffbs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in;
                    n_res  = '0;
                    if (i_in.func == ffbs_pkg::FN_ALLOC) begin
                        n_state = ffbs_pkg::S_AL_START;
                    end else if (!r_svalid[i_in.handle]) begin
                        n_res.status = ffbs_pkg::ST_WILD;
                        n_state      = ffbs_pkg::S_EMIT;
                    end else begin
                        n_state = ffbs_pkg::S_SLOT;
                    end
                end
            end

            ffbs_pkg::S_SLOT: begin
                n_res.blk_no   = srdata[ffbs_pkg::SLOTD_W-1 -: BW];
                n_res.offset   = srdata[2*SW-1:SW];
                n_res.capacity = srdata[SW-1:0];
                n_b   = ffbs_pkg::BCNT_W'(srdata[ffbs_pkg::SLOTD_W-1 -: BW]);
                n_off = srdata[2*SW-1:SW];
                n_cap = srdata[SW-1:0];
                n_state = ffbs_pkg::S_EMIT;
                priority if (r_item.func == ffbs_pkg::FN_FREE && infl_h != '0) begin
                    n_pend[r_item.handle] = 1'b1;
                    n_res.status = ffbs_pkg::ST_DEFERRED;
                end else if (r_item.func == ffbs_pkg::FN_ACQUIRE) begin
                    if (r_pend[r_item.handle] || infl_h == '1) begin
                        n_res.status = ffbs_pkg::ST_REFUSED;
                    end else begin
                        n_infl[r_item.handle] = infl_h + 1'b1;
                    end
                end else if (r_item.func == ffbs_pkg::FN_RELEASE && infl_h == '0) begin
                    n_res.status = ffbs_pkg::ST_UNDERFLOW;
                end else if (r_item.func == ffbs_pkg::FN_RELEASE &&
                             !(infl_h == ffbs_pkg::INFL_W'(1) && r_pend[r_item.handle])) begin
                    n_infl[r_item.handle] = infl_h - 1'b1;
                end else begin
                    // free completes now: return the range to its block
                    n_svalid[r_item.handle] = 1'b0;
                    n_pend[r_item.handle]   = 1'b0;
                    n_infl[r_item.handle]   = '0;
                    n_res.freed = 1'b1;
                    n_n = r_cnt[srdata[ffbs_pkg::SLOTD_W-1 -: BW]];
                    n_i = '0;
                    n_state = ffbs_pkg::S_FR_SCAN;
                end
            end

            ffbs_pkg::S_AL_START: begin
                n_b = '0;
                n_i = '0;
                n_h = fs_idx;
                n_a = sz.req;
                priority if (r_item.alloc_size == '0) begin
                    n_res.status = ffbs_pkg::ST_ZERO;
                    n_state      = ffbs_pkg::S_EMIT;
                end else if (!fs_found) begin
                    n_res.status = ffbs_pkg::ST_NO_SLOT;
                    n_state      = ffbs_pkg::S_EMIT;
                end else if (sz.req_ovf) begin
                    n_res.status = ffbs_pkg::ST_NO_BLOCK;
                    n_state      = ffbs_pkg::S_EMIT;
                end else begin
                    n_state = ffbs_pkg::S_AL_SCAN;
                end
            end

            ffbs_pkg::S_AL_SCAN: begin
                priority if (r_b == ffbs_pkg::BCNT_W'(NB)) begin
                    n_state = ffbs_pkg::S_AL_NEW;
                end else if (!r_bvalid[cur_b] || r_i >= r_cnt[cur_b]) begin
                    n_b = r_b + 1'b1;
                    n_i = '0;
                end else begin
                    n_state = ffbs_pkg::S_AL_CMP;
                end
            end

            ffbs_pkg::S_AL_CMP: begin
                if (rd_l >= r_a) begin
                    // take the front of this range
                    swe = 1'b1;
                    n_svalid[r_h] = 1'b1;
                    n_pend[r_h]   = 1'b0;
                    n_infl[r_h]   = '0;
                    n_res.status     = ffbs_pkg::ST_OK;
                    n_res.new_handle = r_h;
                    n_res.blk_no     = cur_b;
                    n_res.offset     = rd_s;
                    n_res.capacity   = r_a;
                    if (rd_l != r_a) begin
                        rwe     = 1'b1;
                        rwdata  = {rd_s + r_a, rd_l - r_a};
                        n_state = ffbs_pkg::S_EMIT;
                    end else begin
                        n_n = r_cnt[cur_b];
                        n_cnt[cur_b] = r_cnt[cur_b] - 1'b1;
                        n_k = r_i;
                        n_state = ffbs_pkg::S_SHL_RD;
                    end
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = ffbs_pkg::S_AL_SCAN;
                end
            end

            ffbs_pkg::S_AL_NEW: begin
                n_state = ffbs_pkg::S_EMIT;
                if (!nb_found) begin
                    n_res.status = ffbs_pkg::ST_NO_BLOCK;
                end else begin
                    n_bvalid[nb_idx] = 1'b1;
                    rwaddr = ffbs_pkg::f_raddr(nb_idx, '0);
                    rwdata = {r_a, bsize - r_a};
                    if (bsize > r_a) begin
                        rwe = 1'b1;
                        n_cnt[nb_idx] = IW'(1);
                    end else begin
                        n_cnt[nb_idx] = '0;
                    end
                    swe    = 1'b1;
                    swdata = {nb_idx, {SW{1'b0}}, r_a};
                    n_svalid[r_h] = 1'b1;
                    n_pend[r_h]   = 1'b0;
                    n_infl[r_h]   = '0;
                    n_res.status     = ffbs_pkg::ST_OK;
                    n_res.new_handle = r_h;
                    n_res.blk_no     = nb_idx;
                    n_res.offset     = '0;
                    n_res.capacity   = r_a;
                end
            end

            ffbs_pkg::S_FR_SCAN, ffbs_pkg::S_FR_CMP: begin
                if (r_state == ffbs_pkg::S_FR_SCAN && r_i < r_n) begin
                    n_state = ffbs_pkg::S_FR_CMP;
                end else if (r_state == ffbs_pkg::S_FR_CMP && rd_s <= r_off) begin
                    n_ps = rd_s;
                    n_pl = rd_l;
                    n_i  = r_i + 1'b1;
                    n_state = ffbs_pkg::S_FR_SCAN;
                end else begin
                    n_state = ffbs_pkg::S_EMIT;
                    priority if (jp && jn) begin
                        rwe    = 1'b1;
                        rwaddr = ffbs_pkg::f_raddr(cur_b, r_i - 1'b1);
                        rwdata = {r_ps, r_pl + r_cap + rd_l};
                        n_cnt[cur_b] = r_n - 1'b1;
                        n_k = r_i;
                        n_state = ffbs_pkg::S_SHL_RD;
                    end else if (jp) begin
                        rwe    = 1'b1;
                        rwaddr = ffbs_pkg::f_raddr(cur_b, r_i - 1'b1);
                        rwdata = {r_ps, r_pl + r_cap};
                    end else if (jn) begin
                        rwe    = 1'b1;
                        rwdata = {r_off, rd_l + r_cap};
                    end else if (r_n < IW'(ffbs_pkg::RANGES)) begin
                        n_cnt[cur_b] = r_n + 1'b1;
                        n_k = r_n;
                        n_state = ffbs_pkg::S_SHR_RD;
                    end
                end
            end

            // close the gap at r_k: entry k+1 moves to k
            ffbs_pkg::S_SHL_RD: begin
                rraddr = ffbs_pkg::f_raddr(cur_b, r_k + 1'b1);
                if ((r_k + 1'b1) < r_n) begin
                    n_state = ffbs_pkg::S_SHL_WR;
                end else begin
                    n_state = ffbs_pkg::S_EMIT;
                end
            end

            ffbs_pkg::S_SHL_WR: begin
                rwe    = 1'b1;
                rwaddr = ffbs_pkg::f_raddr(cur_b, r_k);
                rwdata = rrdata;
                n_k    = r_k + 1'b1;
                n_state = ffbs_pkg::S_SHL_RD;
            end

            // open a gap at r_i: entry k-1 moves to k, then insert
            ffbs_pkg::S_SHR_RD: begin
                rraddr = ffbs_pkg::f_raddr(cur_b, r_k - 1'b1);
                if (r_k > r_i) begin
                    n_state = ffbs_pkg::S_SHR_WR;
                end else begin
                    rwe     = 1'b1;
                    rwdata  = {r_off, r_cap};
                    n_state = ffbs_pkg::S_EMIT;
                end
            end

            ffbs_pkg::S_SHR_WR: begin
                rwe    = 1'b1;
                rwaddr = ffbs_pkg::f_raddr(cur_b, r_k);
                rwdata = rrdata;
                n_k    = r_k - 1'b1;
                n_state = ffbs_pkg::S_SHR_RD;
            end

            ffbs_pkg::S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ffbs_pkg::S_IDLE;
                end
            end

            default: n_state = ffbs_pkg::S_IDLE;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffbs_pkg::S_IDLE;
            r_bvalid <= '0;
            r_svalid <= '0;
            r_pend   <= '0;
            for (int b = 0; b < NB; b++) begin
                r_cnt[b] <= '0;
            end
            for (int s = 0; s < NS; s++) begin
                r_infl[s] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_bvalid <= n_bvalid;
            r_svalid <= n_svalid;
            r_pend   <= n_pend;
            r_cnt    <= n_cnt;
            r_infl   <= n_infl;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_res  <= n_res;
        r_b <= n_b; r_i <= n_i; r_n <= n_n; r_k <= n_k; r_h <= n_h;
        r_a <= n_a; r_off <= n_off; r_cap <= n_cap; r_ps <= n_ps; r_pl <= n_pl;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ffbs_pkg::S_EMIT && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ffbs_pkg::S_EMIT && (!r_out_valid || i_out_ready)) begin
            r_out <= r_res;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= SW'(16777216);
            r_align_bytes <= ffbs_pkg::AL_W'(256);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == ffbs_pkg::CFG_BLOCK_BYTES) begin
                r_block_bytes <= i_cfg_data;
            end else if (i_cfg_index == ffbs_pkg::CFG_ALIGN_BYTES) begin
                r_align_bytes <= i_cfg_data[ffbs_pkg::AL_W-1:0];
            end
        end
    end
endmodule

@@ sv/ffbs_checker.sv @@
// Port-level checker for the first-fit block suballocator, bound to the top.
// Depends on ffbs_pkg and first_fit_block_suballocator.
module ffbs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ffbs_pkg::t_out_item o_out
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // one item at a time: after a transfer in, input is busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // space is returned only by a successful item
    a_freed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.freed |-> o_out.status == ffbs_pkg::ST_OK)
        else $error("freed with error status");

    // a nonzero handle is handed out only on success
    a_handle_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.new_handle != '0 |-> o_out.status == ffbs_pkg::ST_OK)
        else $error("handle with error status");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind first_fit_block_suballocator ffbs_checker u_ffbs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
);
